### rtl/ezad_pkg.sv
// Shared types, widths and constants of the EMA z-score anomaly detector.
package ezad_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int KIND_W    = 1;
    localparam int CHORD_W   = 3;
    localparam int F0_W      = 21;
    localparam int Q_W       = 16;
    localparam int ALPHA_W   = 16;
    localparam int Z_W       = 16;
    localparam int PERSIST_W = 8;
    localparam int CNT_W     = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Input values are widened to 24 fraction bits.
    localparam int WIDEN_SH = 16;
    localparam int MF_W = F0_W + WIDEN_SH;     // mean_freq, Q13.24
    localparam int MQ_W = Q_W + WIDEN_SH;      // mean_quality, Q8.24
    localparam int AF_W = MF_W - 12;           // truncated deviation, frequency
    localparam int AQ_W = MQ_W - 12;           // truncated deviation, quality
    localparam int VF_W = 2 * AF_W - 2;        // var_freq, Q26.22
    localparam int VQ_W = 2 * AQ_W;            // var_quality, Q16.24
    localparam int ZZ_W = 2 * Z_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSIST = 2'd2;

    localparam logic [ALPHA_W-1:0]   ALPHA_RST   = 16'd6554;
    localparam logic [Z_W-1:0]       ZTH_RST     = 16'd768;
    localparam logic [PERSIST_W-1:0] PERSIST_RST = 8'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    localparam logic [MF_W-1:0] SEED_MEAN_F = '0;
    localparam logic [MQ_W-1:0] SEED_MEAN_Q = 32'h5000_0000;      // 80.0
    localparam logic [VF_W-1:0] SEED_VAR_F  = 48'h0000_0040_0000; // 1.0
    localparam logic [VQ_W-1:0] SEED_VAR_Q  = 40'h00_0400_0000;   // 4.0

    typedef struct packed {
        logic [MF_W-1:0]  mean_f;
        logic [MQ_W-1:0]  mean_q;
        logic [VF_W-1:0]  var_f;
        logic [VQ_W-1:0]  var_q;
        logic [CNT_W-1:0] cnt;
    } stat_entry_t;

    localparam stat_entry_t RESET_ENTRY = '{
        mean_f: SEED_MEAN_F,
        mean_q: SEED_MEAN_Q,
        var_f:  SEED_VAR_F,
        var_q:  SEED_VAR_Q,
        cnt:    '0
    };

    // Stage strobes from the sequencer to the arithmetic.
    typedef struct packed {
        logic ema_en;
        logic sq_en;
        logic var_en;
        logic mul_en;
    } ctl_t;

endpackage

### rtl/ema_zscore_anomaly_detector_core.sv
// Top level of the per-channel EMA z-score anomaly detector.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | sink      | in_valid / in_stall  | kind, chord_index, f0_value, q_value
//  out     | source    | out_valid / out_stall| alert, anomaly_count, f0_outlier, q_outlier
//  cfg     | sink      | cfg_we               | cfg_index, cfg_wdata
//
// Sequence: a measurement transaction passes through the states accept/read, mean
// EMA, square, variance EMA, threshold product and compare/write-back before the
// next acceptance; a seed or out-of-range transaction skips square, variance EMA
// and threshold product. The sequence is set by the chain of dependent multiplies
// between the statistics memory read and its write-back (each multiply gets its
// own register stage) and by the idle state in which the next one is accepted.
// Reset: no clearing pass; per-entry valid bits make every channel read as its
// reset baseline (mean quality 80.0, variances 1.0 and 4.0, counter 0) until written.
// Stalls: a finished result waits in the output register while the next
// transaction is accepted; that transaction holds in its last stage, without
// writing back, until the output register frees.
module ema_zscore_anomaly_detector_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // input transactions
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ezad_pkg::KIND_W-1:0]         kind,
    input  logic [ezad_pkg::CHORD_W-1:0]        chord_index,
    input  logic [ezad_pkg::F0_W-1:0]           f0_value,
    input  logic [ezad_pkg::Q_W-1:0]            q_value,
    // result transactions
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                alert,
    output logic [ezad_pkg::CNT_W-1:0]          anomaly_count,
    output logic                                f0_outlier,
    output logic                                q_outlier,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [ezad_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ezad_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CH_W = ezad_pkg::CH_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EMA  = 3'd1;
    localparam logic [2:0] ST_SQ   = 3'd2;
    localparam logic [2:0] ST_VAR  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ezad_pkg::ALPHA_W-1:0]   alpha_reg;
    logic [ezad_pkg::Z_W-1:0]       zth_reg;
    logic [ezad_pkg::PERSIST_W-1:0] persist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= ezad_pkg::ALPHA_RST;
            zth_reg     <= ezad_pkg::ZTH_RST;
            persist_reg <= ezad_pkg::PERSIST_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ezad_pkg::CFG_ALPHA:   alpha_reg   <= cfg_wdata[ezad_pkg::ALPHA_W-1:0];
                ezad_pkg::CFG_ZTH:     zth_reg     <= cfg_wdata[ezad_pkg::Z_W-1:0];
                ezad_pkg::CFG_PERSIST: persist_reg <= cfg_wdata[ezad_pkg::PERSIST_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_accept;
    logic       out_free;
    logic       finish;
    logic       in_range;
    logic [CH_W+ezad_pkg::CHORD_W-1:0] chan_ext;

    // One transaction in flight; the output register decouples the far side.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid || !out_stall;
    assign finish    = (state_reg == ST_DONE) && out_free;
    assign in_range  = 32'(chord_index) < ezad_pkg::NUM_CHANNELS;
    assign chan_ext  = (CH_W + ezad_pkg::CHORD_W)'(chord_index);

    // Transaction fields held for the whole computation
    logic                           kind_reg;
    logic                           valid_ch_reg;
    logic [CH_W-1:0]                chan_reg;
    logic [ezad_pkg::F0_W-1:0]      f0_reg;
    logic [ezad_pkg::Q_W-1:0]       q_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg     <= kind[0];
            valid_ch_reg <= in_range;
            chan_reg     <= chan_ext[CH_W-1:0];
            f0_reg       <= f0_value;
            q_reg        <= q_value;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EMA;
                end
            end
            ST_EMA:
            begin
                // seeds and unknown channels skip the arithmetic
                if (kind_reg || !valid_ch_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:   state_next = ST_VAR;
            ST_VAR:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    ezad_pkg::ctl_t ctl;

    assign ctl.ema_en = (state_reg == ST_EMA);
    assign ctl.sq_en  = (state_reg == ST_SQ);
    assign ctl.var_en = (state_reg == ST_VAR);
    assign ctl.mul_en = (state_reg == ST_MUL);

    // ---------------------------------------------------------------
    // Statistics memory and arithmetic
    // ---------------------------------------------------------------
    ezad_pkg::stat_entry_t rd_entry;
    ezad_pkg::stat_entry_t wr_entry;
    logic                  mem_wr_en;

    ezad_stat_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept && in_range),
        .rd_addr (chan_ext[CH_W-1:0]),
        .rd_data (rd_entry),
        .wr_en   (mem_wr_en),
        .wr_addr (chan_reg),
        .wr_data (wr_entry)
    );

    logic [ezad_pkg::MF_W-1:0] mean_f;
    logic [ezad_pkg::MQ_W-1:0] mean_q;
    logic [ezad_pkg::VF_W-1:0] var_f;
    logic [ezad_pkg::VQ_W-1:0] var_q;
    logic                      f_hit;
    logic                      q_hit;

    ezad_track u_track (
        .clk    (clk),
        .ctl    (ctl),
        .alpha  (alpha_reg),
        .z_thr  (zth_reg),
        .f0     (f0_reg),
        .q      (q_reg),
        .old    (rd_entry),
        .mean_f (mean_f),
        .mean_q (mean_q),
        .var_f  (var_f),
        .var_q  (var_q),
        .f0_out (f_hit),
        .q_out  (q_hit)
    );

    // ---------------------------------------------------------------
    // Counter update and write-back
    // ---------------------------------------------------------------
    logic                       fo;
    logic                       qo;
    logic [ezad_pkg::CNT_W-1:0] cnt_next;

    // Seeds report no outliers; their flags from the skipped stages are stale.
    assign fo = !kind_reg && f_hit;
    assign qo = !kind_reg && q_hit;

    always_comb
    begin
        priority if (kind_reg)
        begin
            cnt_next = '0;
        end
        else if (fo || qo)
        begin
            cnt_next = (rd_entry.cnt == ezad_pkg::CNT_MAX) ? rd_entry.cnt
                                                           : rd_entry.cnt + 1'b1;
        end
        else
        begin
            cnt_next = (rd_entry.cnt == '0) ? rd_entry.cnt : rd_entry.cnt - 1'b1;
        end
    end

    always_comb
    begin
        if (kind_reg)
        begin
            wr_entry.mean_f = {f0_reg, {ezad_pkg::WIDEN_SH{1'b0}}};
            wr_entry.mean_q = ezad_pkg::SEED_MEAN_Q;
            wr_entry.var_f  = ezad_pkg::SEED_VAR_F;
            wr_entry.var_q  = ezad_pkg::SEED_VAR_Q;
        end
        else
        begin
            wr_entry.mean_f = mean_f;
            wr_entry.mean_q = mean_q;
            wr_entry.var_f  = var_f;
            wr_entry.var_q  = var_q;
        end
        wr_entry.cnt = cnt_next;
    end

    assign mem_wr_en = finish && valid_ch_reg;

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic                       out_valid_reg;
    logic                       alert_reg;
    logic [ezad_pkg::CNT_W-1:0] count_reg;
    logic                       fo_reg;
    logic                       qo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Unknown channels return an all-zero result.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            alert_reg <= valid_ch_reg && (cnt_next >= persist_reg);
            count_reg <= valid_ch_reg ? cnt_next : '0;
            fo_reg    <= valid_ch_reg && fo;
            qo_reg    <= valid_ch_reg && qo;
        end
    end

    assign out_valid     = out_valid_reg;
    assign alert         = alert_reg;
    assign anomaly_count = count_reg;
    assign f0_outlier    = fo_reg;
    assign q_outlier     = qo_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result appeared without finishing a transaction");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_EMA)
        else $error("accepted transaction did not start the sequence");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && out_stall) |=> state_reg == ST_DONE)
        else $error("transaction finished while the output register was full");

    a_no_write_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !mem_wr_en)
        else $error("write-back while the result could not be stored");

endmodule

### rtl/ezad_stat_mem.sv
// Per-channel statistics memory with entry valid bits and registered read.
module ezad_stat_mem (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [ezad_pkg::CH_W-1:0]       rd_addr,
    output ezad_pkg::stat_entry_t           rd_data,
    input  logic                            wr_en,
    input  logic [ezad_pkg::CH_W-1:0]       wr_addr,
    input  ezad_pkg::stat_entry_t           wr_data
);

    ezad_pkg::stat_entry_t mem [ezad_pkg::NUM_CHANNELS];

    logic [ezad_pkg::NUM_CHANNELS-1:0] valid_reg;
    logic                              rd_valid_reg;
    ezad_pkg::stat_entry_t             rd_raw_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Untouched entries read as their reset contents.
    assign rd_data = rd_valid_reg ? rd_raw_reg : ezad_pkg::RESET_ENTRY;

endmodule

### rtl/ezad_track.sv
// Mean, variance and threshold arithmetic for the frequency and quality lanes.
module ezad_track (
    input  logic                              clk,
    input  ezad_pkg::ctl_t                    ctl,
    input  logic [ezad_pkg::ALPHA_W-1:0]      alpha,
    input  logic [ezad_pkg::Z_W-1:0]          z_thr,
    input  logic [ezad_pkg::F0_W-1:0]         f0,
    input  logic [ezad_pkg::Q_W-1:0]          q,
    input  ezad_pkg::stat_entry_t             old,
    output logic [ezad_pkg::MF_W-1:0]         mean_f,
    output logic [ezad_pkg::MQ_W-1:0]         mean_q,
    output logic [ezad_pkg::VF_W-1:0]         var_f,
    output logic [ezad_pkg::VQ_W-1:0]         var_q,
    output logic                              f0_out,
    output logic                              q_out
);

    localparam int MF_W = ezad_pkg::MF_W;
    localparam int MQ_W = ezad_pkg::MQ_W;
    localparam int VF_W = ezad_pkg::VF_W;
    localparam int VQ_W = ezad_pkg::VQ_W;
    localparam int AF_W = ezad_pkg::AF_W;
    localparam int AQ_W = ezad_pkg::AQ_W;
    localparam int ZZ_W = ezad_pkg::ZZ_W;
    localparam int PL_W = ZZ_W + 24;             // low partial products
    localparam int PHF_W = ZZ_W + VF_W - 24;     // high partial, frequency
    localparam int PHQ_W = ZZ_W + VQ_W - 24;     // high partial, quality
    localparam int LF_W = 2 * AF_W + 14;         // frequency square at Q.38
    localparam int LQ_W = 2 * AQ_W + 16;         // quality square at Q.40
    localparam int CF_W = ZZ_W + VF_W;
    localparam int CQ_W = ZZ_W + VQ_W;

    logic [MF_W-1:0] x_f;
    logic [MQ_W-1:0] x_q;
    logic signed [ezad_pkg::ALPHA_W:0] a_s;

    assign x_f = {f0, {ezad_pkg::WIDEN_SH{1'b0}}};
    assign x_q = {q, {ezad_pkg::WIDEN_SH{1'b0}}};
    assign a_s = $signed({1'b0, alpha});

    // EMA of the mean: old + round(a * (x - old) / 2^16)
    logic signed [MF_W:0]    dm_f;
    logic signed [MF_W+17:0] pm_f;
    logic signed [MF_W+17:0] rm_f;
    logic signed [MF_W+1:0]  sm_f;
    logic signed [MQ_W:0]    dm_q;
    logic signed [MQ_W+17:0] pm_q;
    logic signed [MQ_W+17:0] rm_q;
    logic signed [MQ_W+1:0]  sm_q;

    assign dm_f = $signed({1'b0, x_f}) - $signed({1'b0, old.mean_f});
    assign pm_f = a_s * dm_f;
    assign rm_f = pm_f + $signed((MF_W+18)'(32768));
    assign sm_f = $signed({2'b00, old.mean_f}) + $signed(rm_f[MF_W+17:16]);

    assign dm_q = $signed({1'b0, x_q}) - $signed({1'b0, old.mean_q});
    assign pm_q = a_s * dm_q;
    assign rm_q = pm_q + $signed((MQ_W+18)'(32768));
    assign sm_q = $signed({2'b00, old.mean_q}) + $signed(rm_q[MQ_W+17:16]);

    logic [MF_W-1:0] mean_f_reg;
    logic [MQ_W-1:0] mean_q_reg;
    logic [ZZ_W-1:0] zz_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.ema_en)
        begin
            mean_f_reg <= sm_f[MF_W-1:0];
            mean_q_reg <= sm_q[MQ_W-1:0];
            zz_reg     <= ZZ_W'(z_thr) * ZZ_W'(z_thr);
        end
    end

    // Deviation from the new mean, truncated to 12 fraction bits, squared
    logic [MF_W-1:0]   ad_f;
    logic [MQ_W-1:0]   ad_q;
    logic [AF_W-1:0]   t_f;
    logic [AQ_W-1:0]   t_q;
    logic [2*AF_W-1:0] sq_f_reg;
    logic [2*AQ_W-1:0] sq_q_reg;

    assign ad_f = (x_f >= mean_f_reg) ? (x_f - mean_f_reg) : (mean_f_reg - x_f);
    assign ad_q = (x_q >= mean_q_reg) ? (x_q - mean_q_reg) : (mean_q_reg - x_q);
    assign t_f  = ad_f[MF_W-1:12];
    assign t_q  = ad_q[MQ_W-1:12];

    always_ff @(posedge clk)
    begin
        if (ctl.sq_en)
        begin
            sq_f_reg <= (2*AF_W)'(t_f) * (2*AF_W)'(t_f);
            sq_q_reg <= (2*AQ_W)'(t_q) * (2*AQ_W)'(t_q);
        end
    end

    // EMA of the squared deviation
    logic [VF_W-1:0]         xv_f;
    logic signed [VF_W:0]    dv_f;
    logic signed [VF_W+17:0] pv_f;
    logic signed [VF_W+17:0] rv_f;
    logic signed [VF_W+1:0]  sv_f;
    logic signed [VQ_W:0]    dv_q;
    logic signed [VQ_W+17:0] pv_q;
    logic signed [VQ_W+17:0] rv_q;
    logic signed [VQ_W+1:0]  sv_q;

    assign xv_f = sq_f_reg[2*AF_W-1:2];
    assign dv_f = $signed({1'b0, xv_f}) - $signed({1'b0, old.var_f});
    assign pv_f = a_s * dv_f;
    assign rv_f = pv_f + $signed((VF_W+18)'(32768));
    assign sv_f = $signed({2'b00, old.var_f}) + $signed(rv_f[VF_W+17:16]);

    assign dv_q = $signed({1'b0, sq_q_reg}) - $signed({1'b0, old.var_q});
    assign pv_q = a_s * dv_q;
    assign rv_q = pv_q + $signed((VQ_W+18)'(32768));
    assign sv_q = $signed({2'b00, old.var_q}) + $signed(rv_q[VQ_W+17:16]);

    logic [VF_W-1:0] var_f_reg;
    logic [VQ_W-1:0] var_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.var_en)
        begin
            var_f_reg <= sv_f[VF_W-1:0];
            var_q_reg <= sv_q[VQ_W-1:0];
        end
    end

    // Z*Z*var in two partial products per lane
    logic [PL_W-1:0]  pf_lo_reg;
    logic [PHF_W-1:0] pf_hi_reg;
    logic [PL_W-1:0]  pq_lo_reg;
    logic [PHQ_W-1:0] pq_hi_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            pf_lo_reg <= PL_W'(zz_reg) * PL_W'(var_f_reg[23:0]);
            pf_hi_reg <= PHF_W'(zz_reg) * PHF_W'(var_f_reg[VF_W-1:24]);
            pq_lo_reg <= PL_W'(zz_reg) * PL_W'(var_q_reg[23:0]);
            pq_hi_reg <= PHQ_W'(zz_reg) * PHQ_W'(var_q_reg[VQ_W-1:24]);
        end
    end

    logic [LF_W-1:0] lhs_f;
    logic [LQ_W-1:0] lhs_q;
    logic [CF_W-1:0] prod_f;
    logic [CQ_W-1:0] prod_q;

    assign lhs_f  = {sq_f_reg, 14'b0};
    assign lhs_q  = {sq_q_reg, 16'b0};
    assign prod_f = {pf_hi_reg, 24'b0} + CF_W'(pf_lo_reg);
    assign prod_q = {pq_hi_reg, 24'b0} + CQ_W'(pq_lo_reg);

    assign f0_out = CF_W'(lhs_f) > prod_f;
    assign q_out  = CQ_W'(lhs_q) > prod_q;

    assign mean_f = mean_f_reg;
    assign mean_q = mean_q_reg;
    assign var_f  = var_f_reg;
    assign var_q  = var_q_reg;

endmodule

### bench/tb.sv
// Self-checking testbench for the per-channel EMA z-score anomaly detector core.
`timescale 1ns / 100ps

module tb;
    import ezad_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 16;     // margin beyond a measurement's full sequence
    localparam int ROUND_ITEMS  = 160;
    localparam int SAT_ITEMS    = 300;
    localparam int SAT_ROUND    = 3;
    localparam int NUM_ROUNDS   = 9;
    localparam int SAT_CHANNEL  = 5;
    localparam int MAX_REPORTS  = 30;
    localparam int F0_MAX       = (1 << F0_W) - 1;
    localparam int Q_MAX        = (1 << Q_W) - 1;
    localparam int QUAL_BASE    = int'(SEED_MEAN_Q >> WIDEN_SH);   // 80.0 in Q8.8

    typedef enum logic [KIND_W-1:0] {
        KIND_MEASURE = 1'b0,
        KIND_SEED    = 1'b1
    } item_kind_e;

    typedef enum {ROW_ITEM, ROW_REG} row_op_e;

    typedef struct packed {
        logic             alert;
        logic [CNT_W-1:0] count;
        logic             f0_hit;
        logic             q_hit;
    } verdict_t;

    typedef struct {
        row_op_e               op;
        item_kind_e            kind;
        logic [CHORD_W-1:0]    chan;
        logic [F0_W-1:0]       f0;
        logic [Q_W-1:0]        q;
        bit                    known;
        verdict_t              res;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } dir_row_t;

    localparam verdict_t NO_EVENT = '0;

    // ------------------------------------------------------------------
    // Block ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind = '0;
    logic [CHORD_W-1:0]    chord_index = '0;
    logic [F0_W-1:0]       f0_value = '0;
    logic [Q_W-1:0]        q_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b1;
    logic                  alert;
    logic [CNT_W-1:0]      anomaly_count;
    logic                  f0_outlier;
    logic                  q_outlier;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    ema_zscore_anomaly_detector_core dut (.*);

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the registers and channel statistics.
    // ------------------------------------------------------------------
    logic [ALPHA_W-1:0]   alpha_cfg   = ALPHA_RST;
    logic [Z_W-1:0]       zth_cfg     = ZTH_RST;
    logic [PERSIST_W-1:0] persist_cfg = PERSIST_RST;

    logic [MF_W-1:0]  chan_mean_f [NUM_CHANNELS];
    logic [MQ_W-1:0]  chan_mean_q [NUM_CHANNELS];
    logic [VF_W-1:0]  chan_var_f  [NUM_CHANNELS];
    logic [VQ_W-1:0]  chan_var_q  [NUM_CHANNELS];
    logic [CNT_W-1:0] chan_cnt    [NUM_CHANNELS];

    verdict_t verdict_fifo [$];     // expected results, oldest first
    dir_row_t dir_rows [$];         // directed stimulus table
    int       base_f [NUM_CHANNELS];   // last seeded frequency, steers random stimulus
    int       calm_left [2];           // remaining no-idle draws, sender and receiver

    int err_cnt     = 0;
    int sent_cnt    = 0;
    int dir_cnt     = 0;
    int write_cnt   = 0;
    int peak_cnt    = 0;
    int alert_cnt   = 0;
    int cycle_cnt   = 0;

    // Weighted average with the new value weighted by alpha, rounded half up.
    // 80 bits hold every intermediate without overflow.
    function automatic logic [79:0] ema_blend(input logic [79:0] prev, input logic [79:0] x);
        logic [79:0] w_new;
        w_new = 80'(alpha_cfg);
        return ((80'd65536 - w_new) * prev + w_new * x + 80'd32768) >> 16;
    endfunction

    // Advance one mean/variance pair; return the squared truncated deviation (Q.24).
    function automatic logic [79:0] track_stat(input logic [79:0] x,
                                               input logic [79:0] mean_old,
                                               input logic [79:0] spread_old,
                                               input int spread_sh,
                                               output logic [79:0] mean_new,
                                               output logic [79:0] spread_new);
        logic [79:0] dev;
        logic [79:0] dev12;
        logic [79:0] sq;
        mean_new   = ema_blend(mean_old, x);
        dev        = (x >= mean_new) ? x - mean_new : mean_new - x;
        dev12      = dev >> 12;
        sq         = dev12 * dev12;
        spread_new = ema_blend(spread_old, sq >> spread_sh);
        return sq;
    endfunction

    // Apply one transaction to the channel statistics and return the result it yields.
    function automatic verdict_t score_transaction(input item_kind_e k,
                                                   input logic [CHORD_W-1:0] chan,
                                                   input logic [F0_W-1:0] f0,
                                                   input logic [Q_W-1:0] q);
        verdict_t    v;
        int          c;
        logic [79:0] f24;
        logic [79:0] q24;
        logic [79:0] m;
        logic [79:0] s;
        logic [79:0] sq_f;
        logic [79:0] sq_q;
        logic [127:0] zz;
        v = NO_EVENT;
        if (int'(chan) >= NUM_CHANNELS)
            return v;
        c   = int'(chan);
        f24 = 80'(f0) << WIDEN_SH;
        q24 = 80'(q) << WIDEN_SH;
        if (k == KIND_SEED)
        begin
            chan_mean_f[c] = f24[MF_W-1:0];
            chan_mean_q[c] = SEED_MEAN_Q;
            chan_var_f[c]  = SEED_VAR_F;
            chan_var_q[c]  = SEED_VAR_Q;
            chan_cnt[c]    = '0;
        end
        else
        begin
            zz   = 128'(zth_cfg) * 128'(zth_cfg);
            sq_f = track_stat(f24, 80'(chan_mean_f[c]), 80'(chan_var_f[c]), 2, m, s);
            chan_mean_f[c] = m[MF_W-1:0];
            chan_var_f[c]  = s[VF_W-1:0];
            sq_q = track_stat(q24, 80'(chan_mean_q[c]), 80'(chan_var_q[c]), 0, m, s);
            chan_mean_q[c] = m[MQ_W-1:0];
            chan_var_q[c]  = s[VQ_W-1:0];
            // Align each square to the fraction of Z*Z*var and compare exactly.
            v.f0_hit = (128'(sq_f) << 14) > zz * 128'(chan_var_f[c]);
            v.q_hit  = (128'(sq_q) << 16) > zz * 128'(chan_var_q[c]);
            if (v.f0_hit || v.q_hit)
            begin
                if (chan_cnt[c] != CNT_MAX)
                    chan_cnt[c] = chan_cnt[c] + 1'b1;
            end
            else if (chan_cnt[c] != '0)
            begin
                chan_cnt[c] = chan_cnt[c] - 1'b1;
            end
        end
        v.count = chan_cnt[c];
        v.alert = (chan_cnt[c] >= persist_cfg);
        return v;
    endfunction

    // Draw a random idle gap; now and then hold a run of zero gaps.
    function automatic int draw_gap(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm_left[side] = $urandom_range(8, 40);
        return $urandom_range(0, 5);
    endfunction

    // Largest threshold the register holds.
    function automatic int Z_MAX_VAL();
        return (1 << Z_W) - 1;
    endfunction

    // ------------------------------------------------------------------
    // Input side: drive at the falling edge, detect acceptance at the rising edge.
    // A valid that stays high for back-to-back transactions is never toggled.
    // ------------------------------------------------------------------
    task automatic drive_item(input item_kind_e k, input logic [CHORD_W-1:0] chan,
                              input logic [F0_W-1:0] f0, input logic [Q_W-1:0] q,
                              input bit known, input verdict_t typed);
        int       gap;
        verdict_t v;
        gap = draw_gap(0);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        kind        <= k;
        chord_index <= chan;
        f0_value    <= f0;
        q_value     <= q;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        // Accepted: advance the predictor and queue what the block must return.
        v = score_transaction(k, chan, f0, q);
        verdict_fifo.push_back(known ? typed : v);
        sent_cnt++;
    endtask

    // Drop valid and wait until every queued result has come back.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (verdict_fifo.size() != 0)
            @(posedge clk);
    endtask

    // Write a register only while the block is idle, then mirror it in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_ALPHA:   alpha_cfg   = ALPHA_W'(value);
            CFG_ZTH:     zth_cfg     = Z_W'(value);
            CFG_PERSIST: persist_cfg = PERSIST_W'(value);
            default:     ;
        endcase
        write_cnt++;
    endtask

    // Build one random transaction. Most follow the channel's baseline with noise
    // of random scale so that outliers and quiet stretches both occur; some seed a
    // channel and some carry arbitrary values. The pinned form hammers one channel
    // with arbitrary measurements to push its counter into saturation.
    task automatic drive_random(input bit pinned);
        item_kind_e         k;
        logic [CHORD_W-1:0] chan;
        int                 r;
        int                 fv;
        int                 qv;
        int                 off;
        chan = pinned ? CHORD_W'(SAT_CHANNEL) : CHORD_W'($urandom_range(0, NUM_CHANNELS - 1));
        r    = $urandom_range(0, 99);
        k    = KIND_MEASURE;
        if (!pinned && r < 8)
        begin
            k  = KIND_SEED;
            fv = $urandom_range(0, F0_MAX);
            qv = $urandom_range(0, Q_MAX);
            base_f[chan] = fv;
        end
        else if (pinned || r < 20)
        begin
            fv = $urandom_range(0, F0_MAX);
            qv = $urandom_range(0, Q_MAX);
        end
        else
        begin
            off = int'($urandom_range(0, 1 << $urandom_range(0, 14)));
            if ($urandom_range(0, 1) == 1)
                off = -off;
            fv  = base_f[chan] + off;
            fv  = (fv < 0) ? 0 : (fv > F0_MAX) ? F0_MAX : fv;
            off = int'($urandom_range(0, 1 << $urandom_range(0, 12)));
            if ($urandom_range(0, 1) == 1)
                off = -off;
            qv  = QUAL_BASE + off;
            qv  = (qv < 0) ? 0 : (qv > Q_MAX) ? Q_MAX : qv;
        end
        drive_item(k, chan, F0_W'(fv), Q_W'(qv), 1'b0, NO_EVENT);
    endtask

    task automatic add_item(input item_kind_e k, input int chan, input int f0, input int q,
                            input bit known, input verdict_t res);
        dir_row_t row;
        row.op      = ROW_ITEM;
        row.kind    = k;
        row.chan    = CHORD_W'(chan);
        row.f0      = F0_W'(f0);
        row.q       = Q_W'(q);
        row.known   = known;
        row.res     = res;
        row.reg_idx = '0;
        row.reg_val = '0;
        dir_rows.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        dir_row_t row;
        row.op      = ROW_REG;
        row.kind    = KIND_MEASURE;
        row.chan    = '0;
        row.f0      = '0;
        row.q       = '0;
        row.known   = 1'b0;
        row.res     = NO_EVENT;
        row.reg_idx = idx;
        row.reg_val = CFG_DATA_W'(value);
        dir_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall for a random gap, then take one result and check it.
    // ------------------------------------------------------------------
    function automatic void cmp_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic check_result();
        verdict_t want;
        if (verdict_fifo.size() == 0)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t: result with nothing expected, expected none, actual %0d/%0d/%0d/%0d",
                         $time, alert, anomaly_count, f0_outlier, q_outlier);
            return;
        end
        want = verdict_fifo.pop_front();
        cmp_field("alert", CNT_W'(want.alert), CNT_W'(alert));
        cmp_field("anomaly_count", want.count, anomaly_count);
        cmp_field("f0_outlier", CNT_W'(want.f0_hit), CNT_W'(f0_outlier));
        cmp_field("q_outlier", CNT_W'(want.q_hit), CNT_W'(q_outlier));
        if (int'(anomaly_count) > peak_cnt)
            peak_cnt = int'(anomaly_count);
        if (alert === 1'b1)
            alert_cnt++;
    endtask

    initial
    begin
        int gap;
        forever
        begin
            gap = draw_gap(1);
            repeat (gap)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            check_result();
        end
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_cnt, verdict_fifo.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, randomized rounds, wind-down.
    // ------------------------------------------------------------------
    initial
    begin
        int       n_items;
        int       a_val;
        int       z_val;
        int       p_val;
        dir_row_t row;

        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            chan_mean_f[c] = SEED_MEAN_F;
            chan_mean_q[c] = SEED_MEAN_Q;
            chan_var_f[c]  = SEED_VAR_F;
            chan_var_q[c]  = SEED_VAR_Q;
            chan_cnt[c]    = '0;
            base_f[c]      = 0;
        end
        calm_left[0] = 0;
        calm_left[1] = 0;

        // Hold reset for a few cycles, release it away from the rising edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table. Typed expectations are the obvious ones: a channel at its
        // reset baseline, a seed, a zero-threshold hit; the rest go through the predictor.
        add_item(KIND_MEASURE, 0, 0, QUAL_BASE, 1'b1, NO_EVENT);   // baseline, no deviation
        add_item(KIND_SEED, 1, F0_MAX, Q_MAX, 1'b1, NO_EVENT);     // seed clears the counter
        add_item(KIND_MEASURE, 1, F0_MAX, Q_MAX, 1'b0, NO_EVENT);
        add_item(KIND_MEASURE, 1, 0, 0, 1'b0, NO_EVENT);           // full-scale drop
        add_item(KIND_MEASURE, 1, 0, 0, 1'b0, NO_EVENT);
        add_item(KIND_MEASURE, 1, F0_MAX, Q_MAX, 1'b0, NO_EVENT);  // full-scale jump back
        add_item(KIND_MEASURE, 2, 21'h0ABCDE, 16'h1234, 1'b0, NO_EVENT);
        add_item(KIND_SEED, 2, 21'h155555, 16'hAAAA, 1'b1, NO_EVENT);
        add_item(KIND_MEASURE, 7, 21'h155555, 16'hAAAA, 1'b0, NO_EVENT);
        add_reg(CFG_PERSIST, 1);
        add_item(KIND_MEASURE, 7, 21'h0AAAAA, 16'h5555, 1'b0, NO_EVENT);
        // Zero threshold: any nonzero truncated deviation is an outlier.
        add_reg(CFG_ZTH, 0);
        add_item(KIND_MEASURE, 3, 1, QUAL_BASE, 1'b1,
                 '{alert: 1'b1, count: 8'd1, f0_hit: 1'b1, q_hit: 1'b0});
        add_item(KIND_MEASURE, 4, 0, QUAL_BASE, 1'b1, NO_EVENT); // zero deviation stays quiet
        add_reg(CFG_ZTH, Z_MAX_VAL());
        add_item(KIND_MEASURE, 3, F0_MAX, 0, 1'b0, NO_EVENT);
        // Near-full alpha drives the variance to zero; zero deviation is then no outlier.
        add_reg(CFG_ALPHA, 16'hFFFF);
        add_item(KIND_SEED, 5, 21'h100000, 0, 1'b1, NO_EVENT);
        add_item(KIND_MEASURE, 5, 21'h100000, QUAL_BASE, 1'b0, NO_EVENT);
        add_item(KIND_MEASURE, 5, 21'h100000, QUAL_BASE, 1'b0, NO_EVENT);
        add_item(KIND_MEASURE, 5, 21'h100000, QUAL_BASE, 1'b0, NO_EVENT);
        add_reg(CFG_ALPHA, 1);
        add_item(KIND_MEASURE, 6, F0_MAX, Q_MAX, 1'b0, NO_EVENT);
        add_reg(CFG_PERSIST, 255);
        add_item(KIND_MEASURE, 6, 0, 0, 1'b0, NO_EVENT);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.op == ROW_REG)
            begin
                write_reg(row.reg_idx, int'(row.reg_val));
            end
            else
            begin
                drive_item(row.kind, row.chan, row.f0, row.q, row.known, row.res);
                dir_cnt++;
            end
        end

        // Randomized rounds, each under its own register setting: the reset values,
        // the extremes, a saturation round on one channel, then random settings.
        for (int round_idx = 0; round_idx < NUM_ROUNDS; round_idx++)
        begin
            case (round_idx)
                0:
                begin
                    a_val = int'(ALPHA_RST);
                    z_val = int'(ZTH_RST);
                    p_val = int'(PERSIST_RST);
                end
                1:
                begin
                    a_val = 65535;
                    z_val = 256;
                    p_val = 1;
                end
                2:
                begin
                    a_val = 1;
                    z_val = 65535;
                    p_val = 255;
                end
                SAT_ROUND:
                begin
                    a_val = $urandom_range(1, 65535);
                    z_val = 0;
                    p_val = 255;
                end
                default:
                begin
                    a_val = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 65535)
                                                        : (1 << $urandom_range(0, 15));
                    z_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 1536);
                    p_val = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                        : $urandom_range(1, 6);
                end
            endcase
            write_reg(CFG_ALPHA, a_val);
            write_reg(CFG_ZTH, z_val);
            write_reg(CFG_PERSIST, p_val);
            n_items = (round_idx == SAT_ROUND) ? SAT_ITEMS : ROUND_ITEMS;
            repeat (n_items) drive_random(round_idx == SAT_ROUND);
        end

        // Wind down: collect every result, then watch for stray ones.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d transactions (%0d directed) across %0d register writes.",
                 sent_cnt, dir_cnt, write_cnt);
        $display("Peak anomaly count %0d; alert seen on %0d results; %0d mismatches.",
                 peak_cnt, alert_cnt, err_cnt);
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### ema_zscore_anomaly_detector_core.f
rtl/ezad_pkg.sv
rtl/ezad_stat_mem.sv
rtl/ezad_track.sv
rtl/ema_zscore_anomaly_detector_core.sv
bench/tb.sv
